@@ rtl/core/lafn_pkg.sv @@
// Shared types, codes and field widths for the layered affine network unit.
`default_nettype none
package lafn_pkg;

  localparam int OP_W       = 2;
  localparam int LAYER_W    = 2;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 4;
  localparam int NL_W       = 3;
  localparam int IW_W       = 5;
  localparam int OW_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
  localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
  localparam logic [OP_W-1:0] OP_ELEMENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_LAYERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPUTE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Beat tags that travel with the memory read data into the MAC.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic res_valid;
    logic busy;
  } mac_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/lafn_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface lafn_in_if
  import lafn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [LAYER_W-1:0]        layer;
  logic [ROW_W-1:0]          row;
  logic [COL_W-1:0]          column;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, layer, row, column, value, input ready);
  modport sink   (input valid, operation, layer, row, column, value, output ready);
endinterface

interface lafn_out_if
  import lafn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result;
  logic [INDEX_W-1:0]        index;
  logic                      last;

  modport source (output valid, result, index, last, input ready);
  modport sink   (input valid, result, index, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lafn_mac.sv @@
// Multiply-accumulate pipeline with bias preload, rounding and 16-bit saturation.
`default_nettype none
module lafn_mac
  import lafn_pkg::*;
#(
  parameter int FRAC_BITS = 12,
  parameter int ACC_W     = 38
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [VALUE_W-1:0] weight,
  input  wire logic signed [VALUE_W-1:0] operand,
  input  wire logic signed [VALUE_W-1:0] bias,
  output mac_stat_t                      stat,
  output logic signed [VALUE_W-1:0]      res
);

  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] SAT_LO = (ACC_W+1)'(-32768);
  localparam logic signed [ACC_W:0] HALF   = (ACC_W+1)'(1 << (FRAC_BITS - 1));

  logic signed [2*VALUE_W-1:0] prod;
  logic signed [VALUE_W-1:0]   bias2;
  logic                        v2;
  logic                        first2;
  logic                        last2;
  logic signed [ACC_W-1:0]     acc;
  logic                        done3;
  logic                        rv4;

  function automatic logic signed [VALUE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] q;
    t = (ACC_W+1)'(a) + HALF;
    q = t >>> FRAC_BITS;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[VALUE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    prod  <= weight * operand;
    bias2 <= bias;
    first2 <= ctl.first;
    last2  <= ctl.last;
    if (v2) begin
      if (first2) begin
        acc <= (ACC_W'(bias2) <<< FRAC_BITS) + ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (done3) begin
      res <= round_sat(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      done3 <= 1'b0;
      rv4   <= 1'b0;
    end else begin
      v2    <= ctl.valid;
      done3 <= v2 && last2;
      rv4   <= done3;
    end
  end

  assign stat.res_valid = rv4;
  assign stat.busy      = v2 || done3 || rv4;

endmodule
`default_nettype wire

@@ rtl/core/layered_affine_network_forward_unit.sv @@
// Load ops are taken while idle. The last input element starts num_layers layer passes
// through the single MAC and its pipeline drain, then results stream out one at a time:
// a new result read issues only once the previous beat has left the output register.
// All layer passes share the one weight memory read port feeding one MAC.
// Reset: synchronous; registers return to num_layers 1, in_width 16, out_width 16, and a
// clearing pass zeroes all stores before input is accepted.
`default_nettype none
module layered_affine_network_forward_unit
  import lafn_pkg::*;
#(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lafn_in_if.sink                    in_ch,
  lafn_out_if.source                 out_ch
);

  localparam int WDEPTH    = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int BDEPTH    = MAX_LAYERS * MAX_WIDTH;
  localparam int VDEPTH    = 3 * MAX_WIDTH;
  localparam int CLR_DEPTH = (WDEPTH > VDEPTH) ? WDEPTH : VDEPTH;
  localparam int WADDR_W   = $clog2(WDEPTH);
  localparam int BADDR_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int VADDR_W   = $clog2(VDEPTH);
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int LCNT_W    = $clog2(MAX_LAYERS + 1);
  localparam int CIDX_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int ACC_W     = 2 * VALUE_W + $clog2(MAX_WIDTH) + 2;

  state_t state;
  state_t state_next;

  logic [NL_W-1:0] num_layers;
  logic [IW_W-1:0] in_width;
  logic [OW_W-1:0] out_width;

  logic [LCNT_W-1:0] nl_eff;
  logic [CNT_W-1:0]  iw_eff;
  logic [CNT_W-1:0]  ow_eff;

  logic [CLR_W-1:0]  clr_cnt;
  logic [LCNT_W-1:0] lyr;
  logic [CIDX_W-1:0] r;
  logic [CIDX_W-1:0] c;
  logic [CIDX_W-1:0] wr_row;
  logic [CNT_W-1:0]  k;
  logic              pend;
  logic              v1;
  logic              first1;
  logic              last1;
  logic              xzero1;

  logic signed [VALUE_W-1:0] weight_mem [WDEPTH];
  logic signed [VALUE_W-1:0] bias_mem   [BDEPTH];
  logic signed [VALUE_W-1:0] vec_mem    [VDEPTH];
  logic signed [VALUE_W-1:0] wq;
  logic signed [VALUE_W-1:0] bq;
  logic signed [VALUE_W-1:0] vq;

  logic               w_we;
  logic [WADDR_W-1:0] w_waddr;
  logic [WADDR_W-1:0] w_raddr;
  logic signed [VALUE_W-1:0] w_wdata;
  logic               b_we;
  logic [BADDR_W-1:0] b_waddr;
  logic [BADDR_W-1:0] b_raddr;
  logic signed [VALUE_W-1:0] b_wdata;
  logic               v_we;
  logic [VADDR_W-1:0] v_waddr;
  logic [VADDR_W-1:0] v_raddr;
  logic signed [VALUE_W-1:0] v_wdata;

  logic [1:0] src_region;
  logic [1:0] dst_region;
  logic [1:0] fin_region;

  logic in_ready;
  logic issue;
  logic emit_issue;
  logic clearing;
  logic in_acc;
  logic elem_ok;
  logic elem_last;
  logic row_end;
  logic layer_end;
  logic drained;
  logic last_layer;
  logic emit_last;

  mac_ctl_t                  ctl;
  mac_stat_t                 stat;
  logic signed [VALUE_W-1:0] mac_res;
  logic signed [VALUE_W-1:0] operand;

  // Clamp the registers into their usable ranges.
  always_comb begin
    if (num_layers == '0) begin
      nl_eff = LCNT_W'(1);
    end else if (32'(num_layers) > MAX_LAYERS) begin
      nl_eff = LCNT_W'(MAX_LAYERS);
    end else begin
      nl_eff = LCNT_W'(num_layers);
    end
    if (in_width == '0) begin
      iw_eff = CNT_W'(1);
    end else if (32'(in_width) > MAX_WIDTH) begin
      iw_eff = CNT_W'(MAX_WIDTH);
    end else begin
      iw_eff = CNT_W'(in_width);
    end
    if (out_width == '0) begin
      ow_eff = CNT_W'(1);
    end else if (32'(out_width) > MAX_WIDTH) begin
      ow_eff = CNT_W'(MAX_WIDTH);
    end else begin
      ow_eff = CNT_W'(out_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers <= NL_W'(1);
      in_width   <= IW_W'(16);
      out_width  <= OW_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_LAYERS: num_layers <= cfg_data[NL_W-1:0];
        REG_IN_WIDTH:   in_width   <= cfg_data[IW_W-1:0];
        REG_OUT_WIDTH:  out_width  <= cfg_data[OW_W-1:0];
        default:        ;
      endcase
    end
  end

  // Ping-pong between two scratch regions; region zero keeps the input elements.
  always_comb begin
    if (lyr == '0) begin
      src_region = 2'd0;
    end else begin
      src_region = lyr[0] ? 2'd1 : 2'd2;
    end
    dst_region = lyr[0] ? 2'd2 : 2'd1;
    fin_region = last_layer ? dst_region : 2'd1;
  end

  assign in_acc     = in_ch.valid && in_ready;
  assign elem_ok    = (in_ch.operation == OP_ELEMENT) && (32'(in_ch.column) < MAX_WIDTH);
  assign elem_last  = elem_ok && (32'(in_ch.column) == 32'(iw_eff) - 1);
  assign row_end    = 32'(c) == MAX_WIDTH - 1;
  assign layer_end  = row_end && (32'(r) == MAX_WIDTH - 1);
  assign drained    = !v1 && !stat.busy;
  assign last_layer = lyr == nl_eff - LCNT_W'(1);
  assign emit_last  = k == ow_eff - CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (32'(clr_cnt) == CLR_DEPTH - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && elem_last) begin
          state_next = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        if (layer_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_next = last_layer ? ST_EMIT : ST_COMPUTE;
        end
      end
      ST_EMIT: begin
        if (pend && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    emit_issue = 1'b0;
    clearing   = 1'b0;
    case (state)
      ST_CLEAR:   clearing   = 1'b1;
      ST_IDLE:    in_ready   = 1'b1;
      ST_COMPUTE: issue      = 1'b1;
      ST_DRAIN:   ;
      ST_EMIT:    emit_issue = !pend && !out_ch.valid;
      default:    ;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      lyr     <= '0;
      r       <= '0;
      c       <= '0;
      wr_row  <= '0;
      k       <= '0;
      pend    <= 1'b0;
      v1      <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      if (clearing) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (state == ST_IDLE && in_acc && elem_last) begin
        lyr    <= '0;
        r      <= '0;
        c      <= '0;
        wr_row <= '0;
      end
      if (issue) begin
        c <= row_end ? '0 : c + CIDX_W'(1);
        if (row_end) begin
          r <= (32'(r) == MAX_WIDTH - 1) ? '0 : r + CIDX_W'(1);
        end
      end
      if (stat.res_valid) begin
        wr_row <= wr_row + CIDX_W'(1);
      end
      if (state == ST_DRAIN && drained) begin
        wr_row <= '0;
        if (last_layer) begin
          k <= '0;
        end else begin
          lyr <= lyr + LCNT_W'(1);
        end
      end
      // Hold one read in flight; advance when the output register takes it.
      if (emit_issue) begin
        pend <= 1'b1;
      end else if (pend) begin
        pend <= 1'b0;
        k    <= k + CNT_W'(1);
      end
    end
  end

  // Stage one tags: column zero preloads bias, the last column closes the row.
  always_ff @(posedge clk) begin
    first1 <= c == '0;
    last1  <= row_end;
    xzero1 <= (lyr == '0) && (32'(c) >= 32'(iw_eff));
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = WADDR_W'((32'(in_ch.layer) * MAX_WIDTH + 32'(in_ch.row)) * MAX_WIDTH
                       + 32'(in_ch.column));
    w_wdata = in_ch.value;
    b_we    = 1'b0;
    b_waddr = BADDR_W'(32'(in_ch.layer) * MAX_WIDTH + 32'(in_ch.row));
    b_wdata = in_ch.value;
    v_we    = 1'b0;
    v_waddr = VADDR_W'(in_ch.column);
    v_wdata = in_ch.value;
    if (clearing) begin
      w_we    = 32'(clr_cnt) < WDEPTH;
      w_waddr = WADDR_W'(clr_cnt);
      w_wdata = '0;
      b_we    = 32'(clr_cnt) < BDEPTH;
      b_waddr = BADDR_W'(clr_cnt);
      b_wdata = '0;
      v_we    = 32'(clr_cnt) < VDEPTH;
      v_waddr = VADDR_W'(clr_cnt);
      v_wdata = '0;
    end else if (stat.res_valid) begin
      v_we    = 1'b1;
      v_waddr = VADDR_W'(32'(dst_region) * MAX_WIDTH + 32'(wr_row));
      v_wdata = mac_res;
    end else if (in_acc) begin
      w_we = (in_ch.operation == OP_WEIGHT) && (32'(in_ch.layer) < MAX_LAYERS)
             && (32'(in_ch.row) < MAX_WIDTH) && (32'(in_ch.column) < MAX_WIDTH);
      b_we = (in_ch.operation == OP_BIAS) && (32'(in_ch.layer) < MAX_LAYERS)
             && (32'(in_ch.row) < MAX_WIDTH);
      v_we = elem_ok;
    end
  end

  always_comb begin
    w_raddr = WADDR_W'((32'(lyr) * MAX_WIDTH + 32'(r)) * MAX_WIDTH + 32'(c));
    b_raddr = BADDR_W'(32'(lyr) * MAX_WIDTH + 32'(r));
    if (state == ST_EMIT) begin
      v_raddr = VADDR_W'(32'(fin_region) * MAX_WIDTH + 32'(k));
    end else begin
      v_raddr = VADDR_W'(32'(src_region) * MAX_WIDTH + 32'(c));
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= w_wdata;
    end
    wq <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[b_waddr] <= b_wdata;
    end
    bq <= bias_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vec_mem[v_waddr] <= v_wdata;
    end
    vq <= vec_mem[v_raddr];
  end

  // Stale elements past in_width read as zero in the first layer.
  assign operand   = xzero1 ? '0 : vq;
  assign ctl.valid = v1;
  assign ctl.first = first1;
  assign ctl.last  = last1;

  lafn_mac #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .weight  (wq),
    .operand (operand),
    .bias    (bq),
    .stat    (stat),
    .res     (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pend) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_ch.result <= vq;
      out_ch.index  <= INDEX_W'(k);
      out_ch.last   <= emit_last;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for the layered affine network unit: directed table, then random phases.
`timescale 1ns / 100ps
module tb_top;
  import lafn_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int LAYERS = 4;
  localparam int WIDTH = 16;
  localparam int FRAC = 12;
  localparam int ITEM_TARGET = 260;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } out_beat_t;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_val;
    logic [OP_W-1:0]           op;
    logic [LAYER_W-1:0]        lyr;
    logic [ROW_W-1:0]          r;
    logic [COL_W-1:0]          c;
    logic signed [VALUE_W-1:0] v;
    bit                        known;
    logic signed [VALUE_W-1:0] known_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  // typed-in expectation, travels alongside the input beat
  logic known_on;
  logic signed [VALUE_W-1:0] known_val;

  lafn_in_if  in_ch();
  lafn_out_if out_ch();

  // shadow of the network state
  logic signed [VALUE_W-1:0] weights [LAYERS][WIDTH][WIDTH];
  logic signed [VALUE_W-1:0] biases [LAYERS][WIDTH];
  logic signed [VALUE_W-1:0] inputs [WIDTH];
  logic [NL_W-1:0] nl_reg;
  logic [IW_W-1:0] iw_reg;
  logic [OW_W-1:0] ow_reg;

  out_beat_t layer_out_q [$];
  stim_row_t directed [$];

  int fails = 0;
  int items_sent = 0;
  int vectors_run = 0;
  int beats_checked = 0;
  int settings_used = 0;
  int src_calm = 0;
  longint cycles = 0;
  bit stall_armed = 1'b0;

  layered_affine_network_forward_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // round half up, floor shift, saturate to 16 bits
  function automatic logic signed [VALUE_W-1:0] round_sat(longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[VALUE_W-1:0];
  endfunction

  function automatic void affine_step(logic [OP_W-1:0] op, logic [LAYER_W-1:0] lyr,
                                      logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                      logic signed [VALUE_W-1:0] v, logic use_known,
                                      logic signed [VALUE_W-1:0] kval);
    int iw, nl, ow;
    longint acc;
    logic signed [VALUE_W-1:0] cur [WIDTH];
    logic signed [VALUE_W-1:0] nxt [WIDTH];
    out_beat_t beat;
    case (op)
      OP_WEIGHT: weights[lyr][r][c] = v;
      OP_BIAS:   biases[lyr][r] = v;
      OP_ELEMENT: begin
        inputs[c] = v;
        iw = clamp_reg(int'(iw_reg), WIDTH);
        if (int'(c) == iw - 1) begin
          nl = clamp_reg(int'(nl_reg), LAYERS);
          ow = clamp_reg(int'(ow_reg), WIDTH);
          // stale elements past in_width read as zero
          for (int i = 0; i < WIDTH; i++) cur[i] = (i < iw) ? inputs[i] : '0;
          for (int l = 0; l < nl; l++) begin
            for (int j = 0; j < WIDTH; j++) begin
              acc = longint'(biases[l][j]) <<< FRAC;
              for (int i = 0; i < WIDTH; i++)
                acc += longint'(weights[l][j][i]) * longint'(cur[i]);
              nxt[j] = round_sat(acc);
            end
            cur = nxt;
          end
          for (int j = 0; j < ow; j++) begin
            beat.result = use_known ? kval : cur[j];
            beat.index = INDEX_W'(j);
            beat.last = (j == ow - 1);
            layer_out_q.insert(layer_out_q.size(), beat);
          end
          vectors_run++;
        end
      end
      default: ;
    endcase
  endfunction

  // mostly no gap, some short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 125) return $urandom_range(1, 3);
    if (r < 145) return $urandom_range(12, 48);
    return 0;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return VALUE_W'(int'($urandom_range(0, 4095)) - 2048);
    if (r < 9) return VALUE_W'($urandom);
    r = $urandom_range(0, 3);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return '0;
    return '1;
  endfunction

  // check output beats, track register writes, predict accepted input beats
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (rst === 1'b0) begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (layer_out_q.size() == 0) begin
          $error("result beat %0d at index %0d with no vector pending",
                 out_ch.result, out_ch.index);
          fails++;
        end else begin
          want = layer_out_q.pop_front();
          if (out_ch.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, out_ch.result);
            fails++;
          end
          if (out_ch.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, out_ch.index);
            fails++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            fails++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_NUM_LAYERS: nl_reg = cfg_data[NL_W-1:0];
          REG_IN_WIDTH:   iw_reg = cfg_data[IW_W-1:0];
          REG_OUT_WIDTH:  ow_reg = cfg_data[OW_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        affine_step(in_ch.operation, in_ch.layer, in_ch.row, in_ch.column, in_ch.value,
                    known_on, known_val);
    end
  end

  initial begin : result_sink
    int gap;
    int calm;
    gap = 0;
    calm = 0;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (stall_armed && out_ch.valid) begin
        // long hold-off: let the block back up into its input
        stall_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= 1'b1;
        gap = pick_gap(calm);
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [LAYER_W-1:0] lyr,
                           logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                           logic signed [VALUE_W-1:0] v, bit use_known = 1'b0,
                           logic signed [VALUE_W-1:0] kval = '0);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.layer <= lyr;
    in_ch.row <= r;
    in_ch.column <= c;
    in_ch.value <= v;
    known_on <= use_known;
    known_val <= kval;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (op != OP_NONE) items_sent++;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold input until every pending beat is out, then let loads settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (layer_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    directed.insert(directed.size(), s);
  endfunction

  function automatic void add_item(logic [OP_W-1:0] op, logic [LAYER_W-1:0] lyr,
                                   logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                   logic signed [VALUE_W-1:0] v, bit known = 1'b0,
                                   logic signed [VALUE_W-1:0] kval = '0);
    stim_row_t s;
    s = '{default: '0};
    s.op = op;
    s.lyr = lyr;
    s.r = r;
    s.c = c;
    s.v = v;
    s.known = known;
    s.known_val = kval;
    directed.insert(directed.size(), s);
  endfunction

  initial begin : stimulus
    bit cfg_open;
    int nl, iw, ow, span, nvec, nload, phase, r, stop;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_WEIGHT;
    in_ch.layer <= '0;
    in_ch.row <= '0;
    in_ch.column <= '0;
    in_ch.value <= '0;
    known_on <= 1'b0;
    known_val <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_NUM_LAYERS;
    cfg_data <= '0;
    rst <= 1'b1;
    for (int l = 0; l < LAYERS; l++)
      for (int j = 0; j < WIDTH; j++) begin
        biases[l][j] = '0;
        for (int i = 0; i < WIDTH; i++) weights[l][j][i] = '0;
      end
    for (int i = 0; i < WIDTH; i++) inputs[i] = '0;
    nl_reg = 3'd1;
    iw_reg = 5'd16;
    ow_reg = 5'd16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // cleared stores at reset defaults: sixteen zeros
    add_item(OP_ELEMENT, 0, 0, 15, 16'sh7FFF, 1'b1, '0);
    // zero layers and zero out_width clamp to one; spare index is ignored
    add_cfg(REG_NUM_LAYERS, 0);
    add_cfg(REG_IN_WIDTH, 2);
    add_cfg(REG_OUT_WIDTH, 0);
    add_cfg(REG_SPARE, 5'h1F);
    add_item(OP_WEIGHT, 0, 0, 0, 16'sh7FFF);
    add_item(OP_WEIGHT, 0, 0, 1, 16'sh7FFF);
    add_item(OP_BIAS, 0, 0, 0, 16'sh7FFF);
    add_item(OP_ELEMENT, 0, 0, 0, 16'sh7FFF);
    add_item(OP_ELEMENT, 0, 0, 1, 16'sh7FFF, 1'b1, 16'sh7FFF);
    add_item(OP_ELEMENT, 0, 0, 1, 16'sh8000);
    add_item(OP_WEIGHT, 0, 0, 1, 16'sh8000);
    add_item(OP_BIAS, 0, 0, 0, 16'sh8000);
    add_item(OP_ELEMENT, 0, 0, 1, 16'sh7FFF, 1'b1, 16'sh8000);
    add_item(OP_NONE, 3, 15, 15, 16'shFFFF);
    // element past in_width is stored but quiet
    add_item(OP_ELEMENT, 0, 0, 5, 16'sh1234);
    add_item(OP_ELEMENT, 0, 0, 0, 16'sh0100);
    // oversize settings clamp to the maximum shape
    add_cfg(REG_NUM_LAYERS, 7);
    add_cfg(REG_IN_WIDTH, 31);
    add_cfg(REG_OUT_WIDTH, 31);
    add_item(OP_WEIGHT, 3, 15, 15, 16'sh7FFF);
    add_item(OP_BIAS, 3, 15, 0, 16'sh4000);
    add_item(OP_ELEMENT, 0, 0, 15, 16'sh1000);
    // half-way rounding in both directions
    add_cfg(REG_NUM_LAYERS, 1);
    add_cfg(REG_IN_WIDTH, 1);
    add_cfg(REG_OUT_WIDTH, 2);
    add_item(OP_BIAS, 0, 0, 0, 16'sh0000);
    add_item(OP_WEIGHT, 0, 0, 0, 16'sh0001);
    add_item(OP_WEIGHT, 0, 1, 0, 16'shFFFF);
    add_item(OP_ELEMENT, 0, 0, 0, 16'sh0800);
    add_item(OP_ELEMENT, 0, 0, 0, 16'shF800);

    cfg_open = 1'b0;
    foreach (directed[n]) begin
      if (directed[n].is_cfg) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
          settings_used++;
        end
        write_reg(directed[n].reg_idx, directed[n].reg_val);
      end else begin
        if (cfg_open) begin
          cfg_write <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(directed[n].op, directed[n].lyr, directed[n].r, directed[n].c,
                  directed[n].v, directed[n].known, directed[n].known_val);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r == 0) nl = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
      else nl = $urandom_range(1, LAYERS);
      r = $urandom_range(0, 9);
      if (r < 7) iw = $urandom_range(1, 6);
      else if (r == 7) iw = WIDTH;
      else if (r == 8) iw = 0;
      else iw = $urandom_range(1, 31);
      ow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
      nvec = $urandom_range(1, 3);
      if (phase == 0) begin
        nl = 2;
        iw = 3;
        ow = 8;
        nvec = 3;
        stall_armed = 1'b1;
      end
      write_reg(REG_NUM_LAYERS, CFG_DATA_W'(nl));
      write_reg(REG_IN_WIDTH, CFG_DATA_W'(iw));
      write_reg(REG_OUT_WIDTH, CFG_DATA_W'(ow));
      cfg_write <= 1'b0;
      settings_used++;
      nl = clamp_reg(nl, LAYERS);
      iw = clamp_reg(iw, WIDTH);
      ow = clamp_reg(ow, WIDTH);
      span = (iw > ow) ? iw : ow;

      for (int vec = 0; vec < nvec; vec++) begin
        nload = (vec == 0) ? $urandom_range(4, 12) : $urandom_range(0, 5);
        // loads aimed mostly at the live part of the network
        for (int k = 0; k < nload; k++)
          send_item($urandom_range(0, 1) ? OP_BIAS : OP_WEIGHT,
                    LAYER_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, nl - 1)
                                                          : $urandom_range(0, 3)),
                    ROW_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, span - 1)
                                                       : $urandom_range(0, 15)),
                    COL_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, span - 1)
                                                       : $urandom_range(0, 15)),
                    pick_value());
        r = $urandom_range(0, 9);
        if (r == 0) begin
          send_item(OP_NONE, LAYER_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                    VALUE_W'($urandom));
        end else if (r == 1 && iw < WIDTH) begin
          send_item(OP_ELEMENT, LAYER_W'($urandom), ROW_W'($urandom),
                    COL_W'($urandom_range(iw, WIDTH - 1)), pick_value());
        end else if (r == 2 && iw > 1) begin
          // broken vector: a prefix that the full vector below overwrites
          stop = $urandom_range(0, iw - 2);
          for (int col = 0; col <= stop; col++)
            send_item(OP_ELEMENT, LAYER_W'($urandom), ROW_W'($urandom), COL_W'(col),
                      pick_value());
        end
        for (int col = 0; col < iw; col++)
          send_item(OP_ELEMENT, LAYER_W'($urandom), ROW_W'($urandom), COL_W'(col),
                    pick_value());
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (layer_out_q.size() != 0) begin
      $error("%0d result beats never arrived", layer_out_q.size());
      fails++;
    end
    $display("summary: %0d items sent, %0d vectors run, %0d result beats compared",
             items_sent, vectors_run, beats_checked);
    $display("summary: %0d register settings incl. clamped extremes, one long output stall",
             settings_used);
    if (fails == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lafn_pkg.sv
rtl/core/lafn_if.sv
rtl/core/lafn_mac.sv
rtl/core/layered_affine_network_forward_unit.sv
tb/tb_top.sv
